// ===== sv/rmf_pkg.sv =====
package rmf_pkg;

  localparam int LineWidth   = 1280;
  localparam int StoredLines = 4;
  localparam int WinSide     = 5;
  localparam int WinSize     = WinSide * WinSide;
  localparam int MedianRank  = 12;
  localparam int Channels    = 3;
  localparam int PixW        = 8;
  localparam int PixBits     = Channels * PixW;
  localparam int ColW        = $clog2(LineWidth);
  localparam int FillW       = $clog2(LineWidth + 1);
  localparam int RowW        = $clog2(StoredLines);
  localparam int RankW       = $clog2(WinSize + 1);

  typedef logic [WinSize-1:0][PixW-1:0] win_t;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
    logic            new_line;
  } pix_in_t;

  typedef struct packed {
    logic [PixW-1:0] red_median;
    logic [PixW-1:0] green_median;
    logic [PixW-1:0] blue_median;
  } pix_out_t;

  typedef struct packed {
    logic cmp;
    logic sel;
  } med_en_t;

endpackage

// ===== sv/rgb_median_filter_5x5.sv =====
// Pipeline: 4 register stages (line memory read, window, compare, rank select).
// Throughput: one pixel per cycle when not stalled; the four line memories are read and written
// in the same cycle, and the median is a compare stage followed by a rank-select stage.
// Reset clears counters, window and pipeline valids; line memory contents are kept,
// and per-line fill counts make never-written entries read as zero.
module rgb_median_filter_5x5 (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rmf_pkg::pix_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rmf_pkg::pix_out_t out_data_o
);

  localparam logic [rmf_pkg::ColW-1:0] LastCol = rmf_pkg::ColW'(rmf_pkg::LineWidth - 1);

  logic                        acc;
  logic                        rdy1, rdy2, rdy3, rdy_o;
  logic                        adv1, adv2, adv3;
  logic                        v1_q, v2_q, v3_q, vo_q;

  logic [rmf_pkg::ColW-1:0]    col_q, col_d, col_cur;
  logic [rmf_pkg::RowW-1:0]    row_q, row_cur;
  logic [rmf_pkg::FillW-1:0]   fill_q [rmf_pkg::StoredLines];
  logic [rmf_pkg::StoredLines-1:0] line_ok_q;
  logic [rmf_pkg::PixBits-1:0] pix_wr;
  logic [rmf_pkg::PixBits-1:0] pix1_q;
  logic [rmf_pkg::PixBits-1:0] rd_data [rmf_pkg::StoredLines];

  rmf_pkg::win_t               win_q [rmf_pkg::Channels];
  rmf_pkg::win_t               win_d [rmf_pkg::Channels];
  logic [rmf_pkg::PixW-1:0]    med [rmf_pkg::Channels];
  rmf_pkg::med_en_t            med_en;

  assign rdy_o = !vo_q || !out_stall_i;
  assign rdy3  = !v3_q || rdy_o;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;
  assign adv3  = v3_q && rdy_o;
  assign adv2  = v2_q && rdy3;
  assign adv1  = v1_q && rdy2;
  assign acc   = in_valid_i && rdy1;
  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy_o) begin
        vo_q <= v3_q;
      end
    end
  end

  assign col_cur = in_data_i.new_line ? '0 : col_q;
  assign row_cur = in_data_i.new_line ? row_q + 1'b1 : row_q;
  assign col_d   = (col_cur == LastCol) ? LastCol : col_cur + 1'b1;
  assign pix_wr  = {in_data_i.red, in_data_i.green, in_data_i.blue};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      for (int k = 0; k < rmf_pkg::StoredLines; k++) begin
        fill_q[k] <= '0;
      end
    end else if (acc) begin
      col_q <= col_d;
      row_q <= row_cur;
      for (int k = 0; k < rmf_pkg::StoredLines; k++) begin
        if (row_cur == rmf_pkg::RowW'(k) &&
            rmf_pkg::FillW'(col_cur) >= fill_q[k]) begin
          fill_q[k] <= rmf_pkg::FillW'(col_cur) + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      pix1_q <= pix_wr;
      for (int k = 0; k < rmf_pkg::StoredLines; k++) begin
        line_ok_q[k] <= rmf_pkg::FillW'(col_cur) < fill_q[k];
      end
    end
  end

  for (genvar k = 0; k < rmf_pkg::StoredLines; k++) begin : g_line
    rmf_line_ram #(
      .Depth (rmf_pkg::LineWidth),
      .Width (rmf_pkg::PixBits)
    ) u_line_ram (
      .clk_i   (clk_i),
      .en_i    (acc),
      .we_i    (acc && row_cur == rmf_pkg::RowW'(k)),
      .addr_i  (col_cur),
      .wdata_i (pix_wr),
      .rdata_o (rd_data[k])
    );
  end

  always_comb begin
    for (int ch = 0; ch < rmf_pkg::Channels; ch++) begin
      for (int r = 0; r < rmf_pkg::WinSide; r++) begin
        for (int c = 0; c < rmf_pkg::WinSide - 1; c++) begin
          win_d[ch][r*rmf_pkg::WinSide + c] = win_q[ch][r*rmf_pkg::WinSide + c + 1];
        end
        if (r < rmf_pkg::StoredLines) begin
          win_d[ch][r*rmf_pkg::WinSide + rmf_pkg::WinSide - 1] = line_ok_q[r] ?
            rd_data[r][(rmf_pkg::Channels-1-ch)*rmf_pkg::PixW +: rmf_pkg::PixW] : '0;
        end else begin
          win_d[ch][r*rmf_pkg::WinSide + rmf_pkg::WinSide - 1] =
            pix1_q[(rmf_pkg::Channels-1-ch)*rmf_pkg::PixW +: rmf_pkg::PixW];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int ch = 0; ch < rmf_pkg::Channels; ch++) begin
        win_q[ch] <= '0;
      end
    end else if (adv1) begin
      win_q <= win_d;
    end
  end

  assign med_en.cmp = adv2;
  assign med_en.sel = adv3;

  for (genvar ch = 0; ch < rmf_pkg::Channels; ch++) begin : g_med
    rmf_median u_median (
      .clk_i (clk_i),
      .en_i  (med_en),
      .win_i (win_q[ch]),
      .med_o (med[ch])
    );
  end

  assign out_valid_o             = vo_q;
  assign out_data_o.red_median   = med[0];
  assign out_data_o.green_median = med[1];
  assign out_data_o.blue_median  = med[2];

`ifndef SYNTHESIS
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= LastCol)
    else $error("column counter beyond last column");

  a_new_line_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_data_i.new_line |=> col_q == rmf_pkg::ColW'(1))
    else $error("new line did not restart column count");

  a_row_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_data_i.new_line |=> row_q == $past(row_q) + 1'b1)
    else $error("new line did not advance row");

  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> v1_q)
    else $error("accepted transfer lost at first stage");
`endif

endmodule

// ===== sv/rmf_line_ram.sv =====
module rmf_line_ram #(
  parameter int Depth = 1280,
  parameter int Width = 24,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem[addr_i];
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rmf_median.sv =====
module rmf_median (
  input  logic                     clk_i,
  input  rmf_pkg::med_en_t         en_i,
  input  rmf_pkg::win_t            win_i,
  output logic [rmf_pkg::PixW-1:0] med_o
);

  localparam logic [rmf_pkg::RankW-1:0] Rank = rmf_pkg::RankW'(rmf_pkg::MedianRank);

  logic [rmf_pkg::WinSize-1:0] cmp_d [rmf_pkg::WinSize];
  logic [rmf_pkg::WinSize-1:0] cmp_q [rmf_pkg::WinSize];
  rmf_pkg::win_t               val_q;
  logic [rmf_pkg::PixW-1:0]    med_d;
  logic [rmf_pkg::PixW-1:0]    med_q;

  // rank = smaller values plus equal values at lower positions
  always_comb begin
    for (int i = 0; i < rmf_pkg::WinSize; i++) begin
      for (int j = 0; j < rmf_pkg::WinSize; j++) begin
        if (j < i) begin
          cmp_d[i][j] = (win_i[j] <= win_i[i]);
        end else if (j > i) begin
          cmp_d[i][j] = (win_i[j] < win_i[i]);
        end else begin
          cmp_d[i][j] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.cmp) begin
      cmp_q <= cmp_d;
      val_q <= win_i;
    end
  end

  always_comb begin
    med_d = '0;
    for (int i = 0; i < rmf_pkg::WinSize; i++) begin
      if (rmf_pkg::RankW'($countones(cmp_q[i])) == Rank) begin
        med_d = med_d | val_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sel) begin
      med_q <= med_d;
    end
  end

  assign med_o = med_q;

endmodule

// ===== verif/testbench.sv =====
module testbench;

  localparam int IdleLimit = 4000;
  localparam int LongHold  = 100;

  typedef enum int {
    FILL_RANDOM,
    FILL_CLUSTER,
    FILL_EXTREME
  } fill_e;

  class median_scoreboard;
    logic [rmf_pkg::PixBits-1:0] line_mem [rmf_pkg::StoredLines][rmf_pkg::LineWidth];
    logic [rmf_pkg::PixW-1:0]    win [rmf_pkg::Channels][rmf_pkg::WinSize];
    logic [rmf_pkg::RowW-1:0]    row;
    int                          column;
    rmf_pkg::pix_out_t           expected_medians[$];
    int                          errors;

    function new();
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      row    = '0;
      column = 0;
      errors = 0;
    endfunction

    // insertion sort of one channel's window, then pick the middle rank
    function logic [rmf_pkg::PixW-1:0] window_median(int ch);
      logic [rmf_pkg::PixW-1:0] sorted [rmf_pkg::WinSize];
      logic [rmf_pkg::PixW-1:0] x;
      int j;
      for (int i = 0; i < rmf_pkg::WinSize; i++) begin
        x = win[ch][i];
        j = i;
        while (j > 0 && sorted[j-1] > x) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = x;
      end
      return sorted[rmf_pkg::MedianRank];
    endfunction

    function void note_pixel(rmf_pkg::pix_in_t p);
      logic [rmf_pkg::PixW-1:0]    px [rmf_pkg::Channels];
      logic [rmf_pkg::PixBits-1:0] word;
      rmf_pkg::pix_out_t           m;
      int                          c;
      px[0] = p.red;
      px[1] = p.green;
      px[2] = p.blue;
      if (p.new_line) begin
        column = 0;
        row    = row + 1'b1;
      end
      c = (column >= rmf_pkg::LineWidth) ? rmf_pkg::LineWidth - 1 : column;
      for (int ch = 0; ch < rmf_pkg::Channels; ch++) begin
        for (int r = 0; r < rmf_pkg::WinSide; r++) begin
          for (int k = 1; k < rmf_pkg::WinSide; k++) begin
            win[ch][r*rmf_pkg::WinSide+k-1] = win[ch][r*rmf_pkg::WinSide+k];
          end
          if (r == rmf_pkg::WinSide - 1) begin
            win[ch][r*rmf_pkg::WinSide+rmf_pkg::WinSide-1] = px[ch];
          end else begin
            word = line_mem[r][c];
            win[ch][r*rmf_pkg::WinSide+rmf_pkg::WinSide-1] =
              word[rmf_pkg::PixBits-rmf_pkg::PixW*(ch+1) +: rmf_pkg::PixW];
          end
        end
      end
      line_mem[row][c] = {p.red, p.green, p.blue};
      m.red_median   = window_median(0);
      m.green_median = window_median(1);
      m.blue_median  = window_median(2);
      expected_medians.push_back(m);
      column = (c < rmf_pkg::LineWidth - 1) ? c + 1 : rmf_pkg::LineWidth - 1;
    endfunction

    function void compare_field(string name, logic [rmf_pkg::PixW-1:0] want,
                                logic [rmf_pkg::PixW-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_median(rmf_pkg::pix_out_t got);
      rmf_pkg::pix_out_t want;
      if (expected_medians.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected none, actual %h", $time, got);
        return;
      end
      want = expected_medians.pop_front();
      compare_field("red_median", want.red_median, got.red_median);
      compare_field("green_median", want.green_median, got.green_median);
      compare_field("blue_median", want.blue_median, got.blue_median);
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  rmf_pkg::pix_in_t  in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  rmf_pkg::pix_out_t out_data_o;

  median_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int quiet          = 0;
  int sent           = 0;

  rgb_median_filter_5x5 u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_left = LongHold;
      hold_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_pixel(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_median(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= IdleLimit) begin
        $display("rgb_median_filter_5x5 test failed");
        $finish;
      end
    end
  end

  function automatic rmf_pkg::pix_in_t make_pixel(fill_e fill, logic nl,
                                                  logic [rmf_pkg::PixW-1:0] base);
    rmf_pkg::pix_in_t p;
    p.new_line = nl;
    case (fill)
      FILL_CLUSTER: begin
        p.red   = base + rmf_pkg::PixW'($urandom_range(0, 7));
        p.green = base + rmf_pkg::PixW'($urandom_range(0, 7));
        p.blue  = base + rmf_pkg::PixW'($urandom_range(0, 7));
      end
      FILL_EXTREME: begin
        p.red   = $urandom_range(0, 1) ? '1 : '0;
        p.green = $urandom_range(0, 1) ? '1 : '0;
        p.blue  = $urandom_range(0, 1) ? '1 : '0;
      end
      default: begin
        p.red   = rmf_pkg::PixW'($urandom);
        p.green = rmf_pkg::PixW'($urandom);
        p.blue  = rmf_pkg::PixW'($urandom);
      end
    endcase
    return p;
  endfunction

  task automatic send_pixel(rmf_pkg::pix_in_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_line(int len, fill_e fill);
    logic [rmf_pkg::PixW-1:0] base;
    base = rmf_pkg::PixW'($urandom);
    for (int i = 0; i < len; i++) send_pixel(make_pixel(fill, i == 0, base));
  endtask

  // flags at random, lines of any length
  task automatic send_noise(int n);
    for (int i = 0; i < n; i++) begin
      send_pixel(make_pixel(FILL_RANDOM, $urandom_range(0, 3) == 0, '0));
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_medians.size() != 0);
  endtask

  task automatic run_lines(int target);
    while (sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        send_noise(8);
      end else begin
        send_line($urandom_range(5, 40), fill_e'($urandom_range(0, 2)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pixel('{red: 8'h00, green: 8'h00, blue: 8'h00, new_line: 1'b0});
    send_pixel('{red: 8'hff, green: 8'hff, blue: 8'hff, new_line: 1'b0});
    send_pixel('{red: 8'hff, green: 8'h00, blue: 8'hff, new_line: 1'b0});
    send_pixel('{red: 8'h00, green: 8'hff, blue: 8'h00, new_line: 1'b0});
    send_pixel('{red: 8'h80, green: 8'h7f, blue: 8'h01, new_line: 1'b0});
    // back-to-back line starts wrap the row counter
    send_pixel('{red: 8'hff, green: 8'hff, blue: 8'hff, new_line: 1'b1});
    send_pixel('{red: 8'h01, green: 8'h02, blue: 8'h03, new_line: 1'b1});
    send_pixel('{red: 8'hfe, green: 8'h7f, blue: 8'h80, new_line: 1'b1});
    send_pixel('{red: 8'h55, green: 8'haa, blue: 8'h55, new_line: 1'b1});
    for (int i = 0; i < 12; i++) begin
      send_pixel('{red: 8'hff, green: 8'hff, blue: 8'hff, new_line: (i == 0)});
    end

    // hold the output while the next line starts streaming in; line runs past the last column
    hold_requests++;
    send_line(rmf_pkg::LineWidth + 6, FILL_RANDOM);
    run_lines(1400);

    send_idle_pct = 71;
    run_lines(1580);

    drain_results();
    send_idle_pct  = 0;
    recv_stall_pct = 71;
    run_lines(1760);

    send_idle_pct  = 10;
    recv_stall_pct = 10;
    run_lines(1950);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_medians.size() == 0) begin
      $display("rgb_median_filter_5x5 test passed");
    end else begin
      $display("rgb_median_filter_5x5 test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rmf_pkg.sv
sv/rmf_line_ram.sv
sv/rmf_median.sv
sv/rgb_median_filter_5x5.sv
verif/testbench.sv
